[hw/rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and constants for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int WIDE_BITS = 2 * WORD_BITS;
    localparam int CNT_BITS  = $clog2(WIDE_BITS + 1);

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic signed [31:0] first_numerator;
        logic signed [31:0] first_denominator;
        logic signed [31:0] second_numerator;
        logic signed [31:0] second_denominator;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_numerator;
        logic signed [31:0] result_denominator;
        logic [1:0]         status;
    } t_out_word;

    // datapath commands
    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_LOAD    = 4'd1;  // capture operands, magnitudes
    localparam logic [3:0] CMD_GCD_DEN = 4'd2;  // gcd setup: b, d
    localparam logic [3:0] CMD_MUL     = 4'd3;  // one step of multiply
    localparam logic [3:0] CMD_DIV     = 4'd4;  // one step of restoring division
    localparam logic [3:0] CMD_SWAP    = 4'd5;  // gcd: a <= b, b <= remainder
    localparam logic [3:0] CMD_SETUP   = 4'd6;  // load operands for next unit
    localparam logic [3:0] CMD_FINISH  = 4'd7;

    typedef struct packed {
        logic [3:0] cmd;
        logic [3:0] sel;
    } t_dp_ctrl;

    typedef struct packed {
        logic zero_den;
        logic div_zero;
        logic is_addsub;
        logic num_zero;
        logic rem_zero;
        logic unit_done;
    } t_dp_stat;

    // setup selections
    localparam logic [3:0] SEL_LCM_Q   = 4'd0;  // divide b by g
    localparam logic [3:0] SEL_LCM_M   = 4'd1;  // lcm = q * d
    localparam logic [3:0] SEL_F1_Q    = 4'd2;  // lcm / b
    localparam logic [3:0] SEL_F1_M    = 4'd3;  // t1 = a * f
    localparam logic [3:0] SEL_F2_Q    = 4'd4;  // lcm / d
    localparam logic [3:0] SEL_F2_M    = 4'd5;  // t2 = c * f, then sum
    localparam logic [3:0] SEL_NUM_M   = 4'd6;  // mul/div numerator product
    localparam logic [3:0] SEL_DEN_M   = 4'd7;  // mul/div denominator product
    localparam logic [3:0] SEL_GCD_RES = 4'd8;  // gcd of num, den
    localparam logic [3:0] SEL_RED_N   = 4'd9;  // num / g
    localparam logic [3:0] SEL_RED_D   = 4'd10; // den / g
    localparam logic [3:0] SEL_GCD_LD  = 4'd11; // gcd divide step setup
    localparam logic [3:0] SEL_STORE   = 4'd12; // store unit result

endpackage

[hw/rtl/rau_datapath.sv]
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, shift-add multiplier and restoring divider
// ----------------------------------------------------------------------------
module rau_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rau_pkg::t_dp_ctrl   i_ctrl,
    input  rau_pkg::t_in_word   i_word,
    output rau_pkg::t_dp_stat   o_stat,
    output rau_pkg::t_out_word  o_result
);

    localparam int W = rau_pkg::WORD_BITS;
    localparam int X = rau_pkg::WIDE_BITS;

    logic [1:0]   r_op;
    logic [W-1:0] r_am, r_bm, r_cm, r_dm;
    logic         r_an, r_bn, r_cn, r_dn;
    logic [X-1:0] r_lcm, r_t1, r_num, r_den, r_g, r_tmp;
    logic         r_t1n, r_numn;
    logic [X-1:0] r_ua, r_ub, r_acc, r_rem;
    logic [rau_pkg::CNT_BITS-1:0] r_cnt;

    logic [X-1:0] n_ua, n_ub, n_acc, n_rem;
    logic [rau_pkg::CNT_BITS-1:0] n_cnt;
    logic [X:0]   w_trial;
    logic [X-1:0] w_shrem;

    function automatic logic [W:0] mag_of(input logic [31:0] v);
        logic [W-1:0] x;
        x = v[W-1:0];
        mag_of = x[W-1] ? {1'b1, W'(-x)} : {1'b0, x};
    endfunction

    logic [W:0] w_a, w_b, w_c, w_d;
    assign w_a = mag_of(i_word.first_numerator);
    assign w_b = mag_of(i_word.first_denominator);
    assign w_c = mag_of(i_word.second_numerator);
    assign w_d = mag_of(i_word.second_denominator);

    // one restoring divide step: r_ua holds dividend bits, r_ub divisor
    assign w_shrem = {r_rem[X-2:0], r_ua[X-1]};
    assign w_trial = {1'b0, w_shrem} - {1'b0, r_ub};

    // signed add of t1 and t2 (t2 is r_acc)
    logic         w_t2n;
    logic [X-1:0] w_sum;
    logic         w_sumn;
    always_comb begin
        w_t2n = (r_cn ^ r_dn) ^ (r_op == rau_pkg::OP_SUB);
        if (r_acc == '0) w_t2n = 1'b0;
        if (r_t1n == w_t2n) begin
            w_sum  = r_t1 + r_acc;
            w_sumn = r_t1n;
        end else if (r_t1 >= r_acc) begin
            w_sum  = r_t1 - r_acc;
            w_sumn = r_t1n;
        end else begin
            w_sum  = r_acc - r_t1;
            w_sumn = w_t2n;
        end
        if (w_sum == '0) w_sumn = 1'b0;
    end

    always_comb begin
        n_ua  = r_ua;
        n_ub  = r_ub;
        n_acc = r_acc;
        n_rem = r_rem;
        n_cnt = r_cnt;
        unique case (i_ctrl.cmd)
            rau_pkg::CMD_MUL: begin
                if (r_ub[0]) n_acc = r_acc + r_ua;
                n_ua  = {r_ua[X-2:0], 1'b0};
                n_ub  = {1'b0, r_ub[X-1:1]};
                n_cnt = r_cnt - 1'b1;
            end
            rau_pkg::CMD_DIV: begin
                if (!w_trial[X]) begin
                    n_rem = w_trial[X-1:0];
                    n_acc = {r_acc[X-2:0], 1'b1};
                end else begin
                    n_rem = w_shrem;
                    n_acc = {r_acc[X-2:0], 1'b0};
                end
                n_ua  = {r_ua[X-2:0], 1'b0};
                n_cnt = r_cnt - 1'b1;
            end
            rau_pkg::CMD_SWAP: begin
                n_ua  = r_ub;
                n_ub  = r_rem;
                n_acc = '0;
                n_rem = '0;
                n_cnt = rau_pkg::CNT_BITS'(X);
            end
            rau_pkg::CMD_GCD_DEN: begin
                n_ua  = X'(r_bm);
                n_ub  = X'(r_dm);
                n_acc = '0;
                n_rem = '0;
                n_cnt = rau_pkg::CNT_BITS'(X);
            end
            rau_pkg::CMD_SETUP: begin
                n_acc = '0;
                n_rem = '0;
                n_cnt = rau_pkg::CNT_BITS'(X);
                case (i_ctrl.sel)
                    rau_pkg::SEL_LCM_Q: begin n_ua = X'(r_bm); n_ub = r_g; end
                    rau_pkg::SEL_LCM_M: begin n_ua = r_tmp;    n_ub = X'(r_dm); end
                    rau_pkg::SEL_F1_Q:  begin n_ua = r_lcm;    n_ub = X'(r_bm); end
                    rau_pkg::SEL_F1_M:  begin n_ua = r_tmp;    n_ub = X'(r_am); end
                    rau_pkg::SEL_F2_Q:  begin n_ua = r_lcm;    n_ub = X'(r_dm); end
                    rau_pkg::SEL_F2_M:  begin n_ua = r_tmp;    n_ub = X'(r_cm); end
                    rau_pkg::SEL_NUM_M: begin
                        n_ua = X'(r_am);
                        n_ub = (r_op == rau_pkg::OP_MUL) ? X'(r_cm) : X'(r_dm);
                    end
                    rau_pkg::SEL_DEN_M: begin
                        n_ua = X'(r_bm);
                        n_ub = (r_op == rau_pkg::OP_MUL) ? X'(r_dm) : X'(r_cm);
                    end
                    rau_pkg::SEL_GCD_RES: begin n_ua = r_num; n_ub = r_den; end
                    rau_pkg::SEL_RED_N: begin n_ua = r_num; n_ub = r_g; end
                    rau_pkg::SEL_RED_D: begin n_ua = r_den; n_ub = r_g; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ua  <= n_ua;
        r_ub  <= n_ub;
        r_acc <= n_acc;
        r_rem <= n_rem;
        if (i_ctrl.cmd == rau_pkg::CMD_LOAD) begin
            r_op <= i_word.op;
            {r_an, r_am} <= w_a;
            {r_bn, r_bm} <= w_b;
            {r_cn, r_cm} <= w_c;
            {r_dn, r_dm} <= w_d;
        end
        if (i_ctrl.cmd == rau_pkg::CMD_SWAP && r_rem == '0) r_g <= r_ub;
        if (i_ctrl.cmd == rau_pkg::CMD_FINISH) begin
            case (i_ctrl.sel)
                rau_pkg::SEL_LCM_Q: r_tmp <= r_acc;
                rau_pkg::SEL_LCM_M: r_lcm <= r_acc;
                rau_pkg::SEL_F1_Q:  r_tmp <= r_acc;
                rau_pkg::SEL_F1_M: begin
                    r_t1  <= r_acc;
                    r_t1n <= (r_an ^ r_bn) && (r_acc != '0);
                end
                rau_pkg::SEL_F2_Q:  r_tmp <= r_acc;
                rau_pkg::SEL_F2_M: begin
                    r_num  <= w_sum;
                    r_numn <= w_sumn;
                    r_den  <= r_lcm;
                end
                rau_pkg::SEL_NUM_M: begin
                    r_num  <= r_acc;
                    r_numn <= (r_op == rau_pkg::OP_MUL) ? (r_an ^ r_cn ^ r_bn ^ r_dn)
                                                        : (r_an ^ r_dn ^ r_bn ^ r_cn);
                end
                rau_pkg::SEL_DEN_M: r_den <= r_acc;
                rau_pkg::SEL_RED_N: r_num <= r_acc;
                rau_pkg::SEL_RED_D: r_den <= r_acc;
                default: ;
            endcase
        end
    end

    // result check and packing
    localparam logic [X-1:0] LIMIT = X'(1) << (W - 1);
    logic w_ovf;
    logic [W-1:0] w_rn;
    always_comb begin
        w_ovf = (r_den > LIMIT - 1'b1) || (r_num > (r_numn ? LIMIT : LIMIT - 1'b1));
        w_rn  = r_numn ? W'(-r_num) : r_num[W-1:0];
        o_result.status             = rau_pkg::ST_OK;
        o_result.result_numerator   = '0;
        o_result.result_denominator = '0;
        if (o_stat.zero_den) begin
            o_result.status = rau_pkg::ST_ZERO_DEN;
        end else if (o_stat.div_zero) begin
            o_result.status = rau_pkg::ST_DIV_ZERO;
        end else if (r_num == '0) begin
            o_result.result_denominator = 32'(1);
        end else if (w_ovf) begin
            o_result.status = rau_pkg::ST_OVERFLOW;
        end else begin
            o_result.result_numerator   = 32'(signed'(w_rn));
            o_result.result_denominator = 32'(r_den[W-1:0]);
        end
    end

    assign o_stat.zero_den  = (r_bm == '0) || (r_dm == '0);
    assign o_stat.div_zero  = (r_op == rau_pkg::OP_DIV) && (r_cm == '0);
    assign o_stat.is_addsub = (r_op == rau_pkg::OP_ADD) || (r_op == rau_pkg::OP_SUB);
    assign o_stat.num_zero  = (r_num == '0);
    assign o_stat.rem_zero  = (r_rem == '0);
    assign o_stat.unit_done = (r_cnt == '0);

endmodule

[hw/rtl/rau_controller.sv]
// ----------------------------------------------------------------------------
// rau_controller
// sequences loading, gcd, multiply and divide steps and output handshake
// ----------------------------------------------------------------------------
module rau_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    input  rau_pkg::t_dp_stat i_stat,
    output rau_pkg::t_dp_ctrl o_ctrl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_GCD   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [3:0] r_sel, n_sel;
    logic       r_gcd_den, n_gcd_den;
    logic       r_valid, n_valid;

    function automatic logic is_mul(input logic [3:0] s);
        is_mul = (s == rau_pkg::SEL_LCM_M) || (s == rau_pkg::SEL_F1_M) ||
                 (s == rau_pkg::SEL_F2_M) || (s == rau_pkg::SEL_NUM_M) ||
                 (s == rau_pkg::SEL_DEN_M);
    endfunction

    assign o_stall = (r_state != S_IDLE) || (r_valid && i_stall);
    assign o_valid = r_valid;

    always_comb begin
        n_state   = r_state;
        n_sel     = r_sel;
        n_gcd_den = r_gcd_den;
        n_valid   = r_valid && i_stall;
        o_ctrl.cmd = rau_pkg::CMD_NONE;
        o_ctrl.sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && !o_stall) begin
                    o_ctrl.cmd = rau_pkg::CMD_LOAD;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.zero_den || i_stat.div_zero) begin
                    n_state = S_DONE;
                end else if (i_stat.is_addsub) begin
                    o_ctrl.cmd = rau_pkg::CMD_GCD_DEN;
                    n_gcd_den  = 1'b1;
                    n_state    = S_GCD;
                end else begin
                    n_sel   = rau_pkg::SEL_NUM_M;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                if (r_sel == rau_pkg::SEL_GCD_RES) begin
                    if (i_stat.num_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_ctrl.cmd = rau_pkg::CMD_SETUP;
                        n_gcd_den  = 1'b0;
                        n_state    = S_GCD;
                    end
                end else begin
                    o_ctrl.cmd = rau_pkg::CMD_SETUP;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.unit_done) begin
                    o_ctrl.cmd = rau_pkg::CMD_FINISH;
                    n_state    = S_SETUP;
                    unique case (r_sel)
                        rau_pkg::SEL_LCM_Q: n_sel = rau_pkg::SEL_LCM_M;
                        rau_pkg::SEL_LCM_M: n_sel = rau_pkg::SEL_F1_Q;
                        rau_pkg::SEL_F1_Q:  n_sel = rau_pkg::SEL_F1_M;
                        rau_pkg::SEL_F1_M:  n_sel = rau_pkg::SEL_F2_Q;
                        rau_pkg::SEL_F2_Q:  n_sel = rau_pkg::SEL_F2_M;
                        rau_pkg::SEL_F2_M:  n_sel = rau_pkg::SEL_GCD_RES;
                        rau_pkg::SEL_NUM_M: n_sel = rau_pkg::SEL_DEN_M;
                        rau_pkg::SEL_DEN_M: n_sel = rau_pkg::SEL_GCD_RES;
                        rau_pkg::SEL_RED_N: n_sel = rau_pkg::SEL_RED_D;
                        default: begin
                            n_sel   = r_sel;
                            n_state = S_DONE;
                        end
                    endcase
                end else begin
                    o_ctrl.cmd = is_mul(r_sel) ? rau_pkg::CMD_MUL : rau_pkg::CMD_DIV;
                end
            end
            S_GCD: begin
                // divide a by b; swap on finish, stop when divisor is zero
                if (i_stat.unit_done) begin
                    o_ctrl.cmd = rau_pkg::CMD_SWAP;
                    if (i_stat.rem_zero) begin
                        n_sel   = r_gcd_den ? rau_pkg::SEL_LCM_Q : rau_pkg::SEL_RED_N;
                        n_state = S_SETUP;
                    end
                end else begin
                    o_ctrl.cmd = rau_pkg::CMD_DIV;
                end
            end
            S_DONE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel     <= rau_pkg::SEL_NUM_M;
            r_gcd_den <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_gcd_den <= n_gcd_den;
            r_valid   <= n_valid;
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accept while busy");
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state) == S_DONE) else $error("stray valid");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.cmd == rau_pkg::CMD_LOAD) |-> (r_state == S_IDLE))
        else $error("load outside idle");

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add, subtract, multiply and divide with gcd reduction
// ----------------------------------------------------------------------------
// One word is taken at a time. Its latency depends on the operands and is
// set by the single shared shift-add multiplier and restoring divider, each
// 64 steps per use, with a setup step before and a finish after: multiply
// and divide take two products, the euclid steps of the final gcd and two
// quotients to reduce; add and subtract add a gcd of the denominators, three
// quotients and three products. The result register lets the finished word
// wait while a new word is not yet taken.
module rational_arithmetic_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rau_pkg::t_in_word  i_word,
    output logic               o_valid,
    input  logic               i_stall,
    output rau_pkg::t_out_word o_word
);

    rau_pkg::t_dp_ctrl  w_ctrl;
    rau_pkg::t_dp_stat  w_stat;
    rau_pkg::t_out_word w_result;
    rau_pkg::t_out_word r_word;

    rau_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    rau_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_word   (i_word),
        .o_stat   (w_stat),
        .o_result (w_result)
    );

    // result held until taken
    always_ff @(posedge i_clk) begin
        if (!(o_valid && i_stall)) r_word <= w_result;
    end
    assign o_word = r_word;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the rational arithmetic unit: random and corner fractions under
// all four operations, results compared with an internal exact predictor
// ----------------------------------------------------------------------------
module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    rau_pkg::t_in_word  i_word;
    logic               o_valid;
    logic               i_stall;
    rau_pkg::t_out_word o_word;

    rational_arithmetic_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    rau_pkg::t_in_word  pending_q[$];
    rau_pkg::t_out_word fraction_q[$];
    int        errors;
    int        cycles;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_cycles;
    bit        in_taken;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic longint unsigned mag32(logic [31:0] x);
        return x[31] ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
    endfunction

    function automatic rau_pkg::t_out_word reduce_fraction(rau_pkg::t_in_word w);
        rau_pkg::t_out_word r;
        longint unsigned am, bm, cm, dm, lcm, m1, m2, nm, den, g;
        bit              an, bn, cn, dn, n1, n2, nn;
        am = mag32(w.first_numerator);   an = w.first_numerator[31];
        bm = mag32(w.first_denominator); bn = w.first_denominator[31];
        cm = mag32(w.second_numerator);  cn = w.second_numerator[31];
        dm = mag32(w.second_denominator); dn = w.second_denominator[31];
        r = '0;
        if (bm == 0 || dm == 0) begin
            r.status = rau_pkg::ST_ZERO_DEN;
            return r;
        end
        if (w.op == rau_pkg::OP_DIV && cm == 0) begin
            r.status = rau_pkg::ST_DIV_ZERO;
            return r;
        end
        if (w.op == rau_pkg::OP_ADD || w.op == rau_pkg::OP_SUB) begin
            lcm = (bm / gcd64(bm, dm)) * dm;
            m1 = am * (lcm / bm); n1 = (an != bn) && m1 != 0;
            m2 = cm * (lcm / dm); n2 = (cn != dn) ^ (w.op == rau_pkg::OP_SUB);
            if (m2 == 0) n2 = 0;
            if (n1 == n2) begin
                nn = n1; nm = m1 + m2;
            end else if (m1 >= m2) begin
                nn = n1; nm = m1 - m2;
            end else begin
                nn = n2; nm = m2 - m1;
            end
            den = lcm;
        end else if (w.op == rau_pkg::OP_MUL) begin
            nm = am * cm; nn = (an != cn) != (bn != dn); den = bm * dm;
        end else begin
            nm = am * dm; nn = (an != dn) != (bn != cn); den = bm * cm;
        end
        if (nm == 0) begin
            nn = 0; den = 1;
        end else begin
            g = gcd64(nm, den);
            nm = nm / g;
            den = den / g;
        end
        if (den > 64'h7FFF_FFFF || nm > (nn ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            r.status = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.result_numerator   = nn ? -nm[31:0] : nm[31:0];
        r.result_denominator = den[31:0];
        r.status             = rau_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, $signed(got), $signed(want), cycles);
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_word  <= pending_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall     <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rau_pkg::t_out_word want;
        cycles   <= cycles + 1;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            fraction_q.push_back(reduce_fraction(i_word));
        if (i_rst_n && o_valid && !i_stall) begin
            if (fraction_q.size() == 0) begin
                report_mismatch("unexpected word", o_word.result_numerator, 32'd0);
            end else begin
                want = fraction_q.pop_front();
                if (o_word.result_numerator !== want.result_numerator)
                    report_mismatch("numerator", o_word.result_numerator,
                                    want.result_numerator);
                if (o_word.result_denominator !== want.result_denominator)
                    report_mismatch("denominator", o_word.result_denominator,
                                    want.result_denominator);
                if (o_word.status !== want.status)
                    report_mismatch("status", o_word.status, want.status);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > 50000000) begin
            $display("timeout");
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(5))
            0: return $urandom_range(9) - 4;
            1: return $urandom_range(200) - 100;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
            3: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(logic [1:0] op, logic [31:0] a, logic [31:0] b,
                            logic [31:0] c, logic [31:0] d);
        rau_pkg::t_in_word w;
        w.op = op;
        w.first_numerator = a;
        w.first_denominator = b;
        w.second_numerator = c;
        w.second_denominator = d;
        pending_q.push_back(w);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_valid) @(posedge i_clk);
        while (fraction_q.size() > 0) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) begin
            add_word(2'($urandom), rand_value(), rand_value(), rand_value(), rand_value());
        end
        drain();
    endtask

    initial begin
        i_clk = 1'b0;
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        in_taken = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_word  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_word(rau_pkg::OP_ADD, 1, 2, 1, 3);
        add_word(rau_pkg::OP_SUB, 1, 2, 1, 2);
        add_word(rau_pkg::OP_MUL, -3, 4, 2, -9);
        add_word(rau_pkg::OP_DIV, 5, 7, -10, 21);
        add_word(rau_pkg::OP_ADD, 1, 0, 1, 3);
        add_word(rau_pkg::OP_MUL, 1, 3, 1, 0);
        add_word(rau_pkg::OP_DIV, 1, 3, 0, 5);
        add_word(rau_pkg::OP_MUL, 0, 7, 5, 9);
        add_word(rau_pkg::OP_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1);
        add_word(rau_pkg::OP_SUB, 32'h8000_0000, 1, 0, 1);
        add_word(rau_pkg::OP_SUB, 0, 1, 32'h8000_0000, 1);
        add_word(rau_pkg::OP_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
        add_word(rau_pkg::OP_DIV, 1, 32'h8000_0000, 1, 1);
        add_word(rau_pkg::OP_DIV, 1, 32'h8000_0000, -1, 1);
        add_word(rau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE,
                 32'h7FFF_FFFF);
        add_word(rau_pkg::OP_ADD, 1, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFE);
        add_word(rau_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000);
        add_word(rau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000);
        add_word(rau_pkg::OP_SUB, 32'h7FFF_FFFF, 1, -1, 1);
        add_word(rau_pkg::OP_DIV, 6, 1, 3, 1);
        drain();

        random_phase(250, 0, 0);
        random_phase(200, 84, 0);
        random_phase(200, 0, 84);
        random_phase(150, 35, 35);

        // long receiver hold-off with the sender streaming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 40000;
        repeat (30) add_word(2'($urandom), rand_value(), rand_value(),
                             rand_value(), rand_value());
        drain();

        random_phase(200, 0, 0);

        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

[files.f]
hw/rtl/rau_pkg.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_controller.sv
hw/rtl/rational_arithmetic_unit.sv
dv/tb_top.sv
